/* rtl/serial_loaded_bank_mapper_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the serial loaded bank mapper
// Clocked on i_clk, disabled while i_rst_n is low, reported by $error.
// ---------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_ASSERT_SVH
`define SERIAL_LOADED_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define SLBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("slbm assertion failed");

// Consequent must hold in the cycle after the antecedent
`define SLBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("slbm assertion failed");

`else

`define SLBM_ASSERT_NOW(label, ante, cons)
`define SLBM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/slbm_pkg.sv */
`default_nettype none
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slbm_pkg
// Request and result types, codes and reset values for the bank mapper.
// ---------------------------------------------------------------------------
package slbm_pkg;

    // Request: one bus access
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    // Result: translated access
    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mapped_address;
    } t_out_item;

    // Access modes
    localparam logic [1:0] MODE_CPU_WRITE = 2'd0;
    localparam logic [1:0] MODE_CPU_READ  = 2'd1;
    localparam logic [1:0] MODE_PPU       = 2'd2;

    // Result targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PRG  = 2'd1;
    localparam logic [1:0] TGT_CHR  = 2'd2;
    localparam logic [1:0] TGT_NT   = 2'd3;

    // PRG banking modes (control bits 3..2)
    localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // Nametable mirroring (control bits 1..0)
    localparam logic [1:0] MIRROR_ONE_LOW  = 2'd0;
    localparam logic [1:0] MIRROR_ONE_HIGH = 2'd1;
    localparam logic [1:0] MIRROR_VERT     = 2'd2;
    localparam logic [1:0] MIRROR_HORZ     = 2'd3;

    // Serial register targets (address bits 14..13)
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR_LO  = 2'd1;
    localparam logic [1:0] SEL_CHR_HI  = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // Configuration register index (paddr bit 2)
    localparam logic REG_IDX_LAST_PRG = 1'b0;

    // Reset values
    localparam logic [5:0] SR_EMPTY         = 6'h20;
    localparam logic [4:0] CTRL_RESET       = 5'h0c;
    localparam logic [4:0] CTRL_PRG_MODE3   = 5'h0c;
    localparam logic [4:0] CHR_LO_RESET     = 5'd0;
    localparam logic [4:0] CHR_HI_RESET     = 5'd1;
    localparam logic [4:0] PRG_SEL_RESET    = 5'd0;
    localparam logic [4:0] LAST_PRG_RESET   = 5'd15;

endpackage

`default_nettype wire

/* rtl/serial_loaded_bank_mapper.sv */
`default_nettype none
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Serially loaded cartridge bank mapper with PRG, CHR and nametable mapping.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_in_valid / o_in_ready with payload i_in_data
//   (mode, address, data). Each request gives exactly one result on
//   o_out_valid / i_out_ready with payload o_out_data (target, address).
//   CPU writes at 0x8000 and above load the mapper registers one bit at a
//   time and come back with target none.
//   A request passes the request register, then the result register.
//   Throughput is one request per cycle while the receiver is ready; the
//   translation is a few muxes between those two registers, and the
//   mapper registers update in the same step so the next request sees them.
//   When the receiver stalls, the result register holds, the request
//   register still fills, and o_in_ready drops only when both are full.
//   The APB port writes the fixed last PRG bank number at byte addresses 0 to 3
//   (paddr bit 2 low); pready is always high and prdata returns the register.
//   Reset (synchronous, active low) empties both registers and returns the
//   mapper state to: serial register empty, control 0x0c, CHR banks 0/1,
//   PRG bank 0, last PRG bank 15.
// ---------------------------------------------------------------------------

`include "serial_loaded_bank_mapper_assert.svh"

module serial_loaded_bank_mapper
    import slbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Mapper state
    logic [5:0] r_shift_reg;
    logic [4:0] r_control;
    logic [4:0] r_chr_lo;
    logic [4:0] r_chr_hi;
    logic [4:0] r_prg_sel;
    logic [4:0] r_last_prg;

    logic [5:0] n_shift_reg;
    logic [4:0] n_control;
    logic [4:0] n_chr_lo;
    logic [4:0] n_chr_hi;
    logic [4:0] n_prg_sel;
    t_out_item  n_out;

    logic        out_free;
    logic        s1_move;
    logic        cfg_wr;
    logic        is_reg_write;
    logic [5:0]  shifted;
    logic [3:0]  bank16;
    logic [13:0] prg_off;
    logic [13:0] ppu_addr;
    logic [18:0] prg_addr;
    logic [18:0] chr_addr;
    logic [18:0] nt_addr;

    // Handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_move     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_LAST_PRG);
    assign prdata = (paddr[2] == REG_IDX_LAST_PRG) ? {27'd0, r_last_prg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_prg <= LAST_PRG_RESET;
        end else if (cfg_wr) begin
            r_last_prg <= pwdata[4:0];
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // PRG translation
    assign bank16  = r_prg_sel[3:0];
    assign prg_off = r_in.address[13:0];

    always_comb begin
        case (r_control[3:2])
            PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                prg_addr = {1'b0, bank16[3:1], r_in.address[14:0]};
            end
            PRG_MODE_FIX_FIRST: begin
                prg_addr = r_in.address[14] ? {1'b0, bank16, prg_off}
                                            : {5'd0, prg_off};
            end
            PRG_MODE_FIX_LAST: begin
                prg_addr = r_in.address[14] ? {r_last_prg, prg_off}
                                            : {1'b0, bank16, prg_off};
            end
            default: begin
                prg_addr = '0;
            end
        endcase
    end

    // CHR translation
    assign ppu_addr = r_in.address[13:0];

    always_comb begin
        if (!r_control[4]) begin
            chr_addr = {2'b00, r_chr_lo[4:1], ppu_addr[12:0]};
        end else if (!ppu_addr[12]) begin
            chr_addr = {2'b00, r_chr_lo, ppu_addr[11:0]};
        end else begin
            chr_addr = {2'b00, r_chr_hi, ppu_addr[11:0]};
        end
    end

    // Nametable translation
    always_comb begin
        case (r_control[1:0])
            MIRROR_ONE_LOW:  nt_addr = {9'd0, ppu_addr[9:0]};
            MIRROR_ONE_HIGH: nt_addr = {7'd0, 1'b1, 1'b0, ppu_addr[9:0]};
            MIRROR_VERT:     nt_addr = {8'd0, ppu_addr[10:0]};
            MIRROR_HORZ:     nt_addr = {7'd0, ppu_addr[11], 1'b0, ppu_addr[9:0]};
            default:         nt_addr = '0;
        endcase
    end

    // Result select
    always_comb begin
        n_out.target         = TGT_NONE;
        n_out.mapped_address = '0;
        case (r_in.mode)
            MODE_CPU_READ: begin
                if (r_in.address[15]) begin
                    n_out.target         = TGT_PRG;
                    n_out.mapped_address = prg_addr;
                end
            end
            MODE_PPU: begin
                if (!ppu_addr[13]) begin
                    n_out.target         = TGT_CHR;
                    n_out.mapped_address = chr_addr;
                end else begin
                    n_out.target         = TGT_NT;
                    n_out.mapped_address = nt_addr;
                end
            end
            default: begin
                n_out.target         = TGT_NONE;
                n_out.mapped_address = '0;
            end
        endcase
    end

    // Serial register load
    assign is_reg_write = s1_move && (r_in.mode == MODE_CPU_WRITE) && r_in.address[15];
    assign shifted      = {r_in.data[0], r_shift_reg[5:1]};

    always_comb begin
        n_shift_reg = r_shift_reg;
        n_control   = r_control;
        n_chr_lo    = r_chr_lo;
        n_chr_hi    = r_chr_hi;
        n_prg_sel   = r_prg_sel;
        if (is_reg_write) begin
            if (r_in.data[7]) begin
                n_shift_reg = SR_EMPTY;
                n_control   = r_control | CTRL_PRG_MODE3;
            end else if (shifted[0]) begin
                n_shift_reg = SR_EMPTY;
                case (r_in.address[14:13])
                    SEL_CONTROL: n_control = shifted[5:1];
                    SEL_CHR_LO:  n_chr_lo  = shifted[5:1];
                    SEL_CHR_HI:  n_chr_hi  = shifted[5:1];
                    SEL_PRG:     n_prg_sel = shifted[5:1];
                    default:     n_control = r_control;
                endcase
            end else begin
                n_shift_reg = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_reg <= SR_EMPTY;
            r_control   <= CTRL_RESET;
            r_chr_lo    <= CHR_LO_RESET;
            r_chr_hi    <= CHR_HI_RESET;
            r_prg_sel   <= PRG_SEL_RESET;
        end else begin
            r_shift_reg <= n_shift_reg;
            r_control   <= n_control;
            r_chr_lo    <= n_chr_lo;
            r_chr_hi    <= n_chr_hi;
            r_prg_sel   <= n_prg_sel;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    // Checks
    `SLBM_ASSERT_NOW(a_sr_never_full, 1'b1, (r_shift_reg[0] == 1'b0) && (r_shift_reg != 6'd0))
    `SLBM_ASSERT_NEXT(a_out_loaded, s1_move, r_out_valid)
    `SLBM_ASSERT_NEXT(a_in_held, r_in_valid && !s1_move, r_in_valid)
    `SLBM_ASSERT_NOW(a_none_is_zero, r_out_valid && (r_out.target == TGT_NONE), r_out.mapped_address == 19'd0)
    `SLBM_ASSERT_NEXT(a_reset_write, is_reg_write && r_in.data[7], (r_control[3:2] == PRG_MODE_FIX_LAST) && (r_shift_reg == SR_EMPTY))

endmodule

`default_nettype wire

/* tb/serial_loaded_bank_mapper_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_loaded_bank_mapper_test
// Self-checking bench for the serial loaded bank mapper. Bus accesses go in
// on a valid/ready channel, and each translated access that comes back is
// compared with a mirror of the mapper state kept in the bench. Directed
// accesses cover reset mapping, serial loads and the APB port, then mostly
// well-formed random loads and reads run under several last-bank settings.
// ---------------------------------------------------------------------------
module serial_loaded_bank_mapper_test;
    import slbm_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         SETTLE_CYCLES   = 4;
    localparam logic [2:0] LAST_PRG_ADDR   = {REG_IDX_LAST_PRG, 2'b00};
    localparam logic [2:0] UNUSED_REG_ADDR = {~REG_IDX_LAST_PRG, 2'b00};
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the mapper state
    logic [5:0]  serial_m;
    logic [4:0]  control_m;
    logic [4:0]  chr_lo_m;
    logic [4:0]  chr_hi_m;
    logic [4:0]  prg_sel_m;
    logic [4:0]  last_prg_m;

    // Translations still owed by the mapper, oldest first
    t_out_item   translation_q[$];

    bit          idling_on;
    int          stall_left;
    int          idle_cycles;
    int          n_requests;
    int          n_results;
    int          n_errors;
    int          n_serial_loads;
    int          n_settings;
    int          n_by_target[4];

    serial_loaded_bank_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Translate one access and advance the mirrored mapper state
    function automatic t_out_item translate_access(t_in_item req);
        t_out_item   res;
        logic [13:0] low14;
        logic [3:0]  bank16;
        logic [4:0]  loaded;
        res    = '0;
        low14  = req.address[13:0];
        bank16 = prg_sel_m[3:0];
        case (req.mode)
            MODE_CPU_WRITE: begin
                if (req.address[15] && req.data[7]) begin
                    serial_m  = SR_EMPTY;
                    control_m = control_m | CTRL_PRG_MODE3;
                end else if (req.address[15]) begin
                    serial_m = {req.data[0], serial_m[5:1]};
                    // marker reached bit 0: five bits are in
                    if (serial_m[0]) begin
                        loaded = serial_m[5:1];
                        case (req.address[14:13])
                            SEL_CONTROL: control_m = loaded;
                            SEL_CHR_LO:  chr_lo_m  = loaded;
                            SEL_CHR_HI:  chr_hi_m  = loaded;
                            SEL_PRG:     prg_sel_m = loaded;
                            default:     ;
                        endcase
                        serial_m = SR_EMPTY;
                        n_serial_loads++;
                    end
                end
            end
            MODE_CPU_READ: begin
                if (req.address[15]) begin
                    res.target = TGT_PRG;
                    case (control_m[3:2])
                        PRG_MODE_32K_A, PRG_MODE_32K_B:
                            res.mapped_address = {1'b0, bank16[3:1], req.address[14:0]};
                        PRG_MODE_FIX_FIRST:
                            res.mapped_address = req.address[14] ? {1'b0, bank16, low14}
                                                                 : {5'd0, low14};
                        PRG_MODE_FIX_LAST:
                            res.mapped_address = req.address[14] ? {last_prg_m, low14}
                                                                 : {1'b0, bank16, low14};
                        default: ;
                    endcase
                end
            end
            MODE_PPU: begin
                if (!low14[13]) begin
                    res.target = TGT_CHR;
                    if (!control_m[4])
                        res.mapped_address = {2'b00, chr_lo_m[4:1], low14[12:0]};
                    else if (!low14[12])
                        res.mapped_address = {2'b00, chr_lo_m, low14[11:0]};
                    else
                        res.mapped_address = {2'b00, chr_hi_m, low14[11:0]};
                end else begin
                    res.target = TGT_NT;
                    case (control_m[1:0])
                        MIRROR_ONE_LOW:  res.mapped_address = {9'd0, low14[9:0]};
                        MIRROR_ONE_HIGH: res.mapped_address = {7'd0, 2'b10, low14[9:0]};
                        MIRROR_VERT:     res.mapped_address = {8'd0, low14[10:0]};
                        MIRROR_HORZ:
                            res.mapped_address = {7'd0, low14[11], 1'b0, low14[9:0]};
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Send one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [1:0] mode, input logic [15:0] address,
                                input logic [7:0] data);
        t_in_item req;
        int       gap;
        req.mode    = mode;
        req.address = address;
        req.data    = data;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        translation_q.push_back(translate_access(req));
        n_requests++;
    endtask

    // Drop valid and hold until every owed translation has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (translation_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write a register over APB, then read the last bank number back
    task automatic program_register(input logic [2:0] addr, input logic [4:0] value);
        logic [26:0] upper;
        upper = 27'($urandom);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {upper, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == LAST_PRG_ADDR) begin
            last_prg_m = value;
            n_settings++;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LAST_PRG_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[4:0] !== last_prg_m) begin
            $display("%0t: last bank readback expected %0d actual %0d",
                     $time, last_prg_m, prdata[4:0]);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reset mapping, the unmapped ranges and the unused mode
    task automatic test_reset_state();
        send_request(MODE_CPU_READ, 16'h8000, 8'h00);
        send_request(MODE_CPU_READ, 16'hbfff, 8'hff);
        send_request(MODE_CPU_READ, 16'hc000, 8'h00);
        send_request(MODE_CPU_READ, 16'hffff, 8'hff);
        send_request(MODE_CPU_READ, 16'h0000, 8'h00);
        send_request(MODE_CPU_READ, 16'h7fff, 8'h00);
        send_request(MODE_CPU_WRITE, 16'h7fff, 8'hff);
        send_request(MODE_PPU, 16'h0000, 8'h00);
        send_request(MODE_PPU, 16'h1fff, 8'h00);
        send_request(MODE_PPU, 16'h2000, 8'h00);
        send_request(MODE_PPU, 16'h3fff, 8'h00);
        send_request(MODE_PPU, 16'hffff, 8'hff);
        send_request(MODE_UNUSED, 16'hffff, 8'hff);
    endtask

    // Serial loads, one of them cut short by a reset write
    task automatic test_serial_load();
        // control: horizontal mirroring, last bank fixed, 4K CHR banks
        repeat (5) send_request(MODE_CPU_WRITE, 16'h8000, 8'h7f);
        send_request(MODE_PPU, 16'h1000, 8'h00);
        send_request(MODE_PPU, 16'h2c00, 8'h00);
        send_request(MODE_CPU_WRITE, 16'he000, 8'h01);
        send_request(MODE_CPU_WRITE, 16'he000, 8'h01);
        send_request(MODE_CPU_WRITE, 16'hffff, 8'h80);
        for (int i = 0; i < 5; i++)
            send_request(MODE_CPU_WRITE, 16'hffff, i[0] ? 8'h7e : 8'h7f);
        send_request(MODE_CPU_READ, 16'h8000, 8'h00);
        send_request(MODE_CPU_READ, 16'hffff, 8'h00);
    endtask

    // Last-bank extremes and a write to an unused register index
    task automatic test_config_port();
        wait_for_results();
        program_register(LAST_PRG_ADDR, 5'd0);
        send_request(MODE_CPU_READ, 16'hc000, 8'h00);
        send_request(MODE_CPU_READ, 16'hffff, 8'h00);
        wait_for_results();
        program_register(LAST_PRG_ADDR, 5'd31);
        send_request(MODE_CPU_READ, 16'hc000, 8'h00);
        send_request(MODE_CPU_READ, 16'hffff, 8'h00);
        wait_for_results();
        program_register(UNUSED_REG_ADDR, 5'($urandom_range(0, 31)));
        send_request(MODE_CPU_READ, 16'hd234, 8'h00);
    endtask

    // Mostly complete serial loads and reads, with some noise
    task automatic test_random_traffic(input int n_items, input bit allow_idling);
        int sent;
        int kind;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            if (allow_idling && $urandom_range(0, 29) == 0)
                idling_on = !idling_on;
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_request(MODE_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hffff)),
                                 8'($urandom_range(128, 255)));
                    sent++;
                end
                repeat (5) send_request(MODE_CPU_WRITE,
                                        16'($urandom_range(16'h8000, 16'hffff)),
                                        8'($urandom_range(0, 127)));
                sent += 5;
            end else if (kind <= 8) begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(MODE_CPU_READ, 16'($urandom_range(16'h8000, 16'hffff)),
                                     8'($urandom_range(0, 255)));
                    else
                        send_request(MODE_PPU, 16'($urandom_range(0, 16'hffff)),
                                     8'($urandom_range(0, 255)));
                end
                sent += burst;
            end else begin
                send_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hffff)),
                             8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // Random traffic under a sweep of last-bank settings
    task automatic test_bank_settings();
        logic [4:0] setting;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       setting = 5'd31;
                1:       setting = 5'd0;
                2:       setting = LAST_PRG_RESET;
                default: setting = 5'($urandom_range(0, 31));
            endcase
            wait_for_results();
            program_register(LAST_PRG_ADDR, setting);
            test_random_traffic(270, 1'b1);
        end
    endtask

    // Stop sending until the mapper has returned everything, then resume
    task automatic test_drain_pause();
        test_random_traffic(40, 1'b1);
        wait_for_results();
        test_random_traffic(40, 1'b1);
    endtask

    // Full-rate traffic with neither side idling
    task automatic test_back_to_back();
        idling_on = 1'b0;
        test_random_traffic(250, 1'b0);
    endtask

    // Receiver: random stall bursts while idling is on
    always @(negedge i_clk) begin
        if (!idling_on) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each returned translation with the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (translation_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with none owed: target %0d address 0x%05h",
                         $time, o_out_data.target, o_out_data.mapped_address);
            end else begin
                want = translation_q.pop_front();
                n_by_target[want.target]++;
                if (o_out_data.target !== want.target) begin
                    n_errors++;
                    $display("%0t: target expected %0d actual %0d",
                             $time, want.target, o_out_data.target);
                end
                if (o_out_data.mapped_address !== want.mapped_address) begin
                    n_errors++;
                    $display("%0t: mapped address expected 0x%05h actual 0x%05h",
                             $time, want.mapped_address, o_out_data.mapped_address);
                end
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a handshake",
                     $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idling_on      = 1'b1;
        stall_left     = 0;
        idle_cycles    = 0;
        n_requests     = 0;
        n_results      = 0;
        n_errors       = 0;
        n_serial_loads = 0;
        n_settings     = 0;
        n_by_target    = '{0, 0, 0, 0};
        serial_m       = SR_EMPTY;
        control_m      = CTRL_RESET;
        chr_lo_m       = CHR_LO_RESET;
        chr_hi_m       = CHR_HI_RESET;
        prg_sel_m      = PRG_SEL_RESET;
        last_prg_m     = LAST_PRG_RESET;

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_serial_load();
        test_config_port();
        test_bank_settings();
        test_drain_pause();
        test_back_to_back();
        wait_for_results();

        $display("Run: %0d requests, %0d results (%0d PRG, %0d CHR, %0d nametable, %0d none)",
                 n_requests, n_results, n_by_target[TGT_PRG], n_by_target[TGT_CHR],
                 n_by_target[TGT_NT], n_by_target[TGT_NONE]);
        $display("Mapper: %0d serial register loads, %0d last-bank settings, %0d mismatches",
                 n_serial_loads, n_settings, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
